// ===== sv/walm_pkg.sv =====
// shared types and constants for the windowed audio level meter
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package walm_pkg;

  localparam int unsigned RING_DEPTH_DEF  = 65536;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  localparam int unsigned RATE_W   = 18;
  localparam int unsigned WIN_W    = 16;
  localparam int unsigned MS_W     = 13;
  localparam int unsigned OUT_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned PROD_W   = MS_W + RATE_W;

  localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 18'd48000;
  localparam logic [MS_W-1:0]   MS_MIN   = 13'd1;
  localparam logic [MS_W-1:0]   MS_MAX   = 13'd5000;
  localparam int unsigned       MS_PER_S = 1000;

  // floor(x / 1000) as (x * RECIP_MS) >> RECIP_SHIFT, exact for x below 2^32
  localparam int unsigned       RECIP_W     = 29;
  localparam int unsigned       RECIP_SHIFT = 38;
  localparam logic [RECIP_W-1:0] RECIP_MS   = 29'd274877907;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE  = 1'b0,
    CFG_RECORDING_ON = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    CMD_SAMPLE  = 1'b0,
    CMD_MEASURE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVN,
    ST_WALK,
    ST_DRAIN,
    ST_DIVM,
    ST_DIVQ,
    ST_SQRT,
    ST_FIN
  } back_state_e;

  typedef struct packed {
    logic [RATE_W-1:0] sample_rate;
    logic              recording_on;
  } cfg_t;

endpackage

`default_nettype wire

// ===== sv/walm_front.sv =====
// front part: configuration registers, queue entry packing, window clamp
// depends on walm_pkg
`timescale 1ns / 1ps
`default_nettype none

module walm_front #(
  parameter int unsigned SAMPLE_BITS = walm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned EW = 1 + 2 * SAMPLE_BITS + walm_pkg::MS_W
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_valid_i,
  input  wire logic [walm_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire logic [walm_pkg::RATE_W-1:0]           cfg_data_i,
  output walm_pkg::cfg_t                             cfg_o,
  input  wire logic                                  cmd_i,
  input  wire logic [SAMPLE_BITS-1:0]                left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]                right_sample_i,
  input  wire logic [walm_pkg::WIN_W-1:0]            window_ms_i,
  output logic [EW-1:0]                              entry_o
);
  import walm_pkg::*;

  cfg_t            cfg_q;
  logic [MS_W-1:0] ms_clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate  <= SAMPLE_RATE_RST;
      cfg_q.recording_on <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SAMPLE_RATE:  cfg_q.sample_rate  <= cfg_data_i;
        CFG_RECORDING_ON: cfg_q.recording_on <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // window clamp to 1..5000 ms
  always_comb begin
    if (window_ms_i == '0) begin
      ms_clamped = MS_MIN;
    end else if (window_ms_i > WIN_W'(MS_MAX)) begin
      ms_clamped = MS_MAX;
    end else begin
      ms_clamped = window_ms_i[MS_W-1:0];
    end
  end

  assign cfg_o   = cfg_q;
  assign entry_o = {cmd_i, right_sample_i, left_sample_i, ms_clamped};

endmodule

`default_nettype wire

// ===== sv/walm_queue.sv =====
// two-entry queue between the front and back parts
// depends on walm_pkg
`timescale 1ns / 1ps
`default_nettype none

module walm_queue #(
  parameter int unsigned EW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [EW-1:0] push_data_i,
  output logic               ready_o,
  output logic               valid_o,
  output logic [EW-1:0]      data_o,
  input  wire logic          pop_i
);
  import walm_pkg::*;

  logic [EW-1:0] entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// ===== sv/walm_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on walm_pkg
`timescale 1ns / 1ps
`default_nettype none

module walm_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 16
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DW-1:0]      quot_o
);
  import walm_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] quot_q;
  logic [VW-1:0] rem_q, div_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [VW:0]   shifted;
  logic          fits;

  assign shifted = {rem_q, quot_q[DW-1]};
  assign fits    = (shifted >= {1'b0, div_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? VW'(shifted - {1'b0, div_q}) : shifted[VW-1:0];
      quot_q <= {quot_q[DW-2:0], fits};
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ===== sv/walm_back.sv =====
// back part: sample ring, window walk, divider and square root sequencing
// depends on walm_pkg and walm_div
`timescale 1ns / 1ps
`default_nettype none

module walm_back #(
  parameter int unsigned RING_DEPTH  = walm_pkg::RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = walm_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned EW = 1 + 2 * SAMPLE_BITS + walm_pkg::MS_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  walm_pkg::cfg_t                    cfg_i,
  input  wire logic                         q_valid_i,
  input  wire logic [EW-1:0]                q_data_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [walm_pkg::OUT_W-1:0]        mean_level_o,
  output logic [walm_pkg::OUT_W-1:0]        rms_level_o,
  output logic [walm_pkg::OUT_W-1:0]        peak_level_o
);
  import walm_pkg::*;

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned NW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned SAW = NW + SB;
  localparam int unsigned QW  = NW + 2 * SB - 1;
  localparam int unsigned DW  = (QW > PROD_W) ? QW : PROD_W;
  localparam int unsigned VW  = NW + 1;
  localparam int unsigned XW  = 2 * SB;
  localparam int unsigned MPW = PROD_W + RECIP_W;
  localparam int unsigned NFW = MPW - RECIP_SHIFT;

  back_state_e state_q, state_d;

  logic [2*SB-1:0] ring_q [RING_DEPTH];
  logic [AW-1:0]   wp_q, addr_q;
  logic            full_q;
  logic [NW-1:0]   n_q, cnt_q;

  logic [2*SB-1:0] rd_data_q;
  logic            v1_q, ok1_q, v2_q;
  logic [SB-1:0]   mag_l_q, mag_r_q;
  logic [2*SB-1:0] sq_l_q, sq_r_q;
  logic [SAW-1:0]  sum_abs_q;
  logic [QW-1:0]   sum_sq_q;
  logic [SB-1:0]   peak_q, mean_q;
  logic [XW-1:0]   x_q, res_q, bit_q;
  logic [PROD_W-1:0] prod_q;

  logic            out_valid_q;
  logic [OUT_W-1:0] mean_out_q, rms_out_q, peak_out_q;

  // queue entry fields
  logic [MS_W-1:0] e_ms;
  logic [SB-1:0]   e_left, e_right;
  logic            e_cmd;
  assign e_ms    = q_data_i[MS_W-1:0];
  assign e_left  = q_data_i[MS_W +: SB];
  assign e_right = q_data_i[MS_W + SB +: SB];
  assign e_cmd   = q_data_i[EW-1];

  logic            ring_we, rd_en, rd_ok;
  logic            div_start, div_busy, div_done;
  logic [DW-1:0]   div_a, div_q;
  logic [VW-1:0]   div_b;
  logic [MPW-1:0]  n_prod;
  logic [NFW-1:0]  n_full;
  logic [NW-1:0]   n_sat;
  logic            start_measure, zero_path, init_walk, fin_load;
  logic            take_mean, init_sqrt, sqrt_step;

  walm_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_q)
  );

  // ms * rate / 1000 by reciprocal multiplication
  assign n_prod = MPW'(prod_q) * MPW'(RECIP_MS);
  assign n_full = n_prod[MPW-1:RECIP_SHIFT];
  assign n_sat  = (n_full > NFW'(RING_DEPTH)) ? NW'(RING_DEPTH) : n_full[NW-1:0];
  assign rd_ok  = full_q || (addr_q < wp_q);

  always_comb begin
    state_d       = state_q;
    q_pop_o       = 1'b0;
    ring_we       = 1'b0;
    rd_en         = 1'b0;
    div_start     = 1'b0;
    div_a         = '0;
    div_b         = '0;
    start_measure = 1'b0;
    zero_path     = 1'b0;
    init_walk     = 1'b0;
    take_mean     = 1'b0;
    init_sqrt     = 1'b0;
    sqrt_step     = 1'b0;
    fin_load      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (cmd_e'(e_cmd) == CMD_SAMPLE) begin
            ring_we = 1'b1;
          end else begin
            start_measure = 1'b1;
            if (cfg_i.recording_on) begin
              state_d = ST_DIVN;
            end else begin
              state_d = ST_FIN;
            end
          end
        end
      end
      ST_DIVN: begin
        if (n_sat == '0) begin
          zero_path = 1'b1;
          state_d   = ST_FIN;
        end else begin
          init_walk = 1'b1;
          state_d   = ST_WALK;
        end
      end
      ST_WALK: begin
        rd_en = 1'b1;
        if (cnt_q == NW'(1)) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          div_start = 1'b1;
          div_a     = DW'(sum_abs_q);
          div_b     = {n_q, 1'b0};
          state_d   = ST_DIVM;
        end
      end
      ST_DIVM: begin
        if (div_done) begin
          take_mean = 1'b1;
          div_start = 1'b1;
          div_a     = DW'(sum_sq_q);
          div_b     = {n_q, 1'b0};
          state_d   = ST_DIVQ;
        end
      end
      ST_DIVQ: begin
        if (div_done) begin
          init_sqrt = 1'b1;
          state_d   = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_q == '0) begin
          state_d = ST_FIN;
        end else begin
          sqrt_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          fin_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // write pointer and wrap flag; entries at or above the pointer before the
  // first wrap were never written and read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      full_q      <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ring_we) begin
        if (wp_q == AW'(RING_DEPTH - 1)) begin
          wp_q   <= '0;
          full_q <= 1'b1;
        end else begin
          wp_q <= wp_q + AW'(1);
        end
      end
      v1_q <= rd_en;
      v2_q <= v1_q;
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[wp_q] <= {e_right, e_left};
    if (rd_en) rd_data_q <= ring_q[addr_q];
  end

  // walk pipeline: read, magnitude and square, accumulate
  logic [SB-1:0] l_raw, r_raw, l_mag, r_mag;
  assign l_raw = rd_data_q[SB-1:0];
  assign r_raw = rd_data_q[2*SB-1:SB];
  assign l_mag = ok1_q ? (l_raw[SB-1] ? SB'(~l_raw + SB'(1)) : l_raw) : '0;
  assign r_mag = ok1_q ? (r_raw[SB-1] ? SB'(~r_raw + SB'(1)) : r_raw) : '0;

  logic [SB-1:0]  peak_lr;
  logic [XW-1:0]  sq_sum, sqrt_trial;
  assign peak_lr    = (mag_l_q > mag_r_q) ? mag_l_q : mag_r_q;
  assign sq_sum     = sq_l_q + sq_r_q;
  assign sqrt_trial = res_q + bit_q;

  always_ff @(posedge clk_i) begin
    ok1_q <= rd_ok;
    if (v1_q) begin
      mag_l_q <= l_mag;
      mag_r_q <= r_mag;
      sq_l_q  <= l_mag * l_mag;
      sq_r_q  <= r_mag * r_mag;
    end
    if (start_measure) begin
      prod_q    <= PROD_W'(e_ms) * PROD_W'(cfg_i.sample_rate);
      sum_abs_q <= '0;
      sum_sq_q  <= '0;
      peak_q    <= '0;
      mean_q    <= '0;
      res_q     <= '0;
    end else if (v2_q) begin
      sum_abs_q <= sum_abs_q + SAW'(mag_l_q) + SAW'(mag_r_q);
      sum_sq_q  <= sum_sq_q + QW'(sq_sum);
      if (peak_lr > peak_q) peak_q <= peak_lr;
    end
    if (init_walk) begin
      n_q    <= n_sat;
      cnt_q  <= n_sat;
      addr_q <= (wp_q == '0) ? AW'(RING_DEPTH - 1) : wp_q - AW'(1);
    end else if (rd_en) begin
      cnt_q  <= cnt_q - NW'(1);
      addr_q <= (addr_q == '0) ? AW'(RING_DEPTH - 1) : addr_q - AW'(1);
    end
    if (take_mean) mean_q <= div_q[SB-1:0];
    if (zero_path) peak_q <= '0;
    if (init_sqrt) begin
      x_q   <= div_q[XW-1:0];
      res_q <= '0;
      bit_q <= XW'(1) << (XW - 2);
    end else if (sqrt_step) begin
      if (x_q >= sqrt_trial) begin
        x_q   <= x_q - sqrt_trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (fin_load) begin
      mean_out_q <= OUT_W'(mean_q);
      rms_out_q  <= OUT_W'(res_q);
      peak_out_q <= OUT_W'(peak_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mean_level_o = mean_out_q;
  assign rms_level_o  = rms_out_q;
  assign peak_level_o = peak_out_q;

`ifndef ASSERT_OFF
  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wp_q <= AW'(RING_DEPTH - 1)) else $error("write pointer past ring end");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> state_q == ST_IDLE) else $error("ring written during measurement");
  a_walk_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> cnt_q != '0) else $error("walk with empty count");
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");
  a_fin_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_load |=> out_valid_o) else $error("result not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/windowed_audio_level_meter.sv =====
// top level of the windowed stereo audio level meter (mean, rms, peak)
// depends on walm_pkg, walm_front, walm_queue, walm_back, walm_div
`timescale 1ns / 1ps
`default_nettype none

// Stereo level meter over a ring of RING_DEPTH stereo samples. An item with
// cmd 0 stores one sample pair at the write pointer. An item with cmd 1
// measures the newest n samples, where n is floor(window_ms * sample_rate /
// 1000) with window_ms clamped to 1..5000 and n saturated to RING_DEPTH, and
// returns one result with mean absolute, rms and peak absolute level. A
// measurement takes the item, turns ms into samples by one reciprocal
// multiply, makes one ring read per sample through a three-stage pipeline,
// runs two passes of a bit-serial divider (mean, mean square) of width DW,
// 48 at the default sizes, and ends with a bit-pair integer square root.
// Items queue behind a running measurement in a two-entry queue, so the
// input side takes up to two more items while the back part is busy or a
// result waits. Ring entries that were never written read as zero through
// a wrap flag, so no clearing pass runs after reset. With recording_on
// clear, or a window under one sample, the result is all zero. Configuration
// is written through its own channel, which is always ready; write it only
// while the meter is idle.
module windowed_audio_level_meter #(
  parameter int unsigned RING_DEPTH  = walm_pkg::RING_DEPTH_DEF,
  parameter int unsigned SAMPLE_BITS = walm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [walm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [walm_pkg::RATE_W-1:0]       cfg_data_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              cmd_i,
  input  wire logic [SAMPLE_BITS-1:0]            left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0]            right_sample_i,
  input  wire logic [walm_pkg::WIN_W-1:0]        window_ms_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [walm_pkg::OUT_W-1:0]             mean_level_o,
  output logic [walm_pkg::OUT_W-1:0]             rms_level_o,
  output logic [walm_pkg::OUT_W-1:0]             peak_level_o
);
  import walm_pkg::*;

  // queue entry: cmd, right, left, clamped window
  localparam int unsigned EW = 1 + 2 * SAMPLE_BITS + MS_W;

  cfg_t          cfg;
  logic [EW-1:0] entry, q_data;
  logic          q_ready, q_valid, q_pop, push;

  // config channel never stalls
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready;
  // an input transfer pushes the packed item straight into the queue
  assign push        = in_valid_i && q_ready;

  walm_front #(.SAMPLE_BITS(SAMPLE_BITS), .EW(EW)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_o          (cfg),
    .cmd_i          (cmd_i),
    .left_sample_i  (left_sample_i),
    .right_sample_i (right_sample_i),
    .window_ms_i    (window_ms_i),
    .entry_o        (entry)
  );

  walm_queue #(.EW(EW)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (entry),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // back part owns the ring, the walk and the result register
  walm_back #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .EW          (EW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_data_i     (q_data),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mean_level_o (mean_level_o),
    .rms_level_o  (rms_level_o),
    .peak_level_o (peak_level_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_windowed_audio_level_meter.sv =====
// self-checking testbench for windowed_audio_level_meter
// depends on walm_pkg and the windowed_audio_level_meter rtl
`timescale 1ns / 1ps

module tb_windowed_audio_level_meter;
  import walm_pkg::*;

  localparam int unsigned DEPTH      = RING_DEPTH_DEF;
  localparam longint      CYCLE_CAP  = 100000000;
  localparam int          SETTLE_CYC = 400;
  localparam int          HOLD_CYC   = 3000;

  typedef struct packed {
    logic [OUT_W-1:0] mean;
    logic [OUT_W-1:0] rms;
    logic [OUT_W-1:0] peak;
  } levels_t;

  // keeps its own copy of the ring and registers and predicts each measurement
  class level_board;
    logic signed [15:0] ring_l [DEPTH];
    logic signed [15:0] ring_r [DEPTH];
    int unsigned        wr_ptr;
    logic [RATE_W-1:0]  rate;
    bit                 rec_on;
    levels_t            pending_levels[$];
    int unsigned        n_measured;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        ring_l[i] = '0;
        ring_r[i] = '0;
      end
      wr_ptr = 0;
      rate = SAMPLE_RATE_RST;
      rec_on = 0;
      n_measured = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [RATE_W-1:0] value);
      if (idx == CFG_SAMPLE_RATE) rate = value;
      else rec_on = value[0];
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function void note_item(cmd_e cmd, logic [15:0] l, logic [15:0] r, logic [15:0] win);
      longint unsigned ms, cnt, head, tail, idx, a, b, s_abs, s_sq, pk;
      levels_t lv;
      if (cmd == CMD_SAMPLE) begin
        ring_l[wr_ptr] = l;
        ring_r[wr_ptr] = r;
        wr_ptr = (wr_ptr + 1) % DEPTH;
        return;
      end
      lv = '0;
      n_measured++;
      if (rec_on) begin
        ms = win;
        if (ms < 1) ms = 1;
        if (ms > 5000) ms = 5000;
        cnt = ms * rate / 1000;
        if (cnt > DEPTH) cnt = DEPTH;
        if (cnt != 0) begin
          head = (wr_ptr < cnt) ? wr_ptr : cnt;
          tail = cnt - head;
          s_abs = 0;
          s_sq = 0;
          pk = 0;
          for (longint unsigned i = 0; i < cnt; i++) begin
            // older part at the end of the ring first, then below the pointer
            idx = (i < tail) ? DEPTH - tail + i : wr_ptr - head + (i - tail);
            a = (ring_l[idx] < 0) ? -longint'(ring_l[idx]) : longint'(ring_l[idx]);
            b = (ring_r[idx] < 0) ? -longint'(ring_r[idx]) : longint'(ring_r[idx]);
            s_abs += a + b;
            s_sq += a * a + b * b;
            if (a > pk) pk = a;
            if (b > pk) pk = b;
          end
          lv.mean = s_abs / (2 * cnt);
          lv.rms = int_sqrt(s_sq / (2 * cnt));
          lv.peak = pk;
        end
      end
      pending_levels.push_back(lv);
    endfunction

    // empty string means the result matched
    function string check_result(logic [OUT_W-1:0] mean, logic [OUT_W-1:0] rms,
                                 logic [OUT_W-1:0] peak);
      levels_t lv;
      string msg;
      if (pending_levels.size() == 0) return "result with nothing expected";
      lv = pending_levels.pop_front();
      msg = "";
      if (mean !== lv.mean) msg = {msg, $sformatf(" mean %0d exp %0d", mean, lv.mean)};
      if (rms !== lv.rms) msg = {msg, $sformatf(" rms %0d exp %0d", rms, lv.rms)};
      if (peak !== lv.peak) msg = {msg, $sformatf(" peak %0d exp %0d", peak, lv.peak)};
      return msg;
    endfunction
  endclass

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             cfg_valid_i = 0;
  logic             cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [RATE_W-1:0] cfg_data_i = '0;
  logic             in_valid_i = 0;
  logic             in_ready_o;
  logic             cmd_i = 0;
  logic [15:0]      left_sample_i = '0;
  logic [15:0]      right_sample_i = '0;
  logic [15:0]      window_ms_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 0;
  logic [OUT_W-1:0] mean_level_o, rms_level_o, peak_level_o;

  level_board  board;
  int          errors = 0;
  longint      cycles = 0;
  int unsigned n_sent = 0;
  bit          hold_req = 0;

  windowed_audio_level_meter u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .cmd_i, .left_sample_i, .right_sample_i, .window_ms_i,
    .out_valid_o, .out_ready_i, .mean_level_o, .rms_level_o, .peak_level_o
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // run limit, far above the slowest legal run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               board.pending_levels.size());
      $display("tb_windowed_audio_level_meter: errors");
      $finish;
    end
  end

  task automatic report(string msg);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // result checker, sampled on the rising edge
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      msg = board.check_result(mean_level_o, rms_level_o, peak_level_o);
      if (msg != "") report(msg);
    end
  end

  // result receiver: random stalls, mostly short, the odd long one,
  // plus a long hold-off on request
  initial begin
    int r;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 0;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_req = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) out_ready_i = 1;
        else if (r < 97) out_ready_i = 0;
        else begin
          out_ready_i = 0;
          repeat ($urandom_range(20, 120)) @(negedge clk_i);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // called at a falling edge; returns at a falling edge after the transfer
  task automatic send_item(cmd_e cmd, logic [15:0] l, logic [15:0] r,
                           logic [15:0] win, int gap);
    in_valid_i = 1;
    cmd_i = cmd;
    left_sample_i = l;
    right_sample_i = r;
    window_ms_i = win;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_item(cmd, l, r, win);
    n_sent++;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic put_sample(logic [15:0] l, logic [15:0] r);
    send_item(CMD_SAMPLE, l, r, 16'($urandom), pick_gap());
  endtask

  task automatic measure(logic [15:0] win);
    send_item(CMD_MEASURE, 16'($urandom), 16'($urandom), win, pick_gap());
  endtask

  // wait for every expected result, then let queued sample writes finish
  task automatic settle();
    in_valid_i = 0;
    while (board.pending_levels.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [RATE_W-1:0] value);
    cfg_valid_i = 1;
    cfg_index_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i = 0;
  endtask

  task automatic set_meter(logic [RATE_W-1:0] rate, bit on);
    settle();
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_RECORDING_ON, RATE_W'(on));
  endtask

  // mostly sample writes, some measurements, windows mostly short
  task automatic random_phase(int items);
    for (int k = 0; k < items; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        if ($urandom_range(0, 99) < 25) measure(16'($urandom));
        else measure(16'($urandom_range(0, 20)));
      end else begin
        put_sample(16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    board = new();
    repeat (6) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: recording off, measure returns zeros but samples still stored
    put_sample(16'h8000, 16'h7fff);
    measure(16'd10);
    set_meter(18'd48000, 1);
    put_sample(16'h0000, 16'hffff);
    put_sample(16'h0001, 16'h8000);
    put_sample(16'h7fff, 16'h0001);
    measure(16'd0);       // zero window counts as one ms
    measure(16'd1);
    measure(16'd5000);    // saturates to the whole ring
    measure(16'hffff);    // above the clamp
    set_meter(18'd999, 1); // under one sample per ms window: empty
    measure(16'd1);
    set_meter(18'd0, 1);
    measure(16'd3000);
    set_meter(18'd192000, 1);
    measure(16'd1);
    set_meter(18'h3ffff, 1);
    measure(16'd0);
    set_meter(18'd8000, 0);
    measure(16'd5000);

    // random with recording on at low rates so windows stay modest
    set_meter(18'd1000, 1);
    random_phase(100);
    set_meter(18'($urandom_range(1000, 3000)), 1);
    random_phase(100);

    // long receiver hold-off while items keep coming, so the input stalls
    hold_req = 1;
    measure(16'd5);
    measure(16'd3);
    for (int k = 0; k < 6; k++) put_sample(16'($urandom), 16'($urandom));
    measure(16'd2);
    settle();

    set_meter(18'($urandom_range(8000, 16000)), 1);
    random_phase(60);
    set_meter(18'd1500, 0);
    random_phase(40);

    // windows that reach past the written part of the ring
    set_meter(18'd1000, 1);
    measure(16'd100);
    measure(16'd41);
    random_phase(60);
    set_meter(18'd192000, 1);
    measure(16'd5000);
    measure(16'd2);

    settle();
    $display("covered %0d transfers, %0d measurements incl. empty, clamped", n_sent,
             board.n_measured);
    $display("and saturated windows, disabled recording and a stalled full input");
    if (errors == 0) begin
      $display("tb_windowed_audio_level_meter: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_windowed_audio_level_meter: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/walm_pkg.sv
sv/walm_front.sv
sv/walm_queue.sv
sv/walm_div.sv
sv/walm_back.sv
sv/windowed_audio_level_meter.sv
dv/tb_windowed_audio_level_meter.sv
